/* rtl/max_priority_queue_fifo_ties_macros.svh */
// Assertion macros for the priority queue RTL.
// Depends on i_clk and i_rst_n being visible at the point of use.
`ifndef MAX_PRIORITY_QUEUE_FIFO_TIES_MACROS_SVH
`define MAX_PRIORITY_QUEUE_FIFO_TIES_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define PQFT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pqft assertion failed");

// Next-cycle implication
`define PQFT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pqft assertion failed");

`else

`define PQFT_ASSERT_NOW(label, ante, cons)
`define PQFT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/pqft_pkg.sv */
// Shared constants, codes and types of the priority queue.
// No dependencies.
package pqft_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int PRIO_W = 8;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STAT_W-1:0] ST_REMOVED   = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    // contents of one slot
    typedef struct packed {
        logic [PRIO_W-1:0]        prio;
        logic signed [DATA_W-1:0] data;
    } t_slot;

    // running best entry handed along the cell chain
    typedef struct packed {
        logic                     any;
        logic [PRIO_W-1:0]        prio;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] data;
    } t_carry;

    // control broadcast to every cell
    typedef struct packed {
        logic             wr_ins;
        logic             shift;
        logic [IDX_W-1:0] best_idx;
        logic [CNT_W-1:0] count;
    } t_cell_ctl;

    // one result word
    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] data;
        logic [PRIO_W-1:0]        prio;
        logic [OCC_W-1:0]         occ;
    } t_rsp;

endpackage

/* rtl/pqft_if.sv */
// Valid/ready channel interfaces for request and response words.
// Depends on pqft_pkg.
interface pqft_req_if import pqft_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic signed [DATA_W-1:0] item_data;
    logic [PRIO_W-1:0]        item_priority;

    modport source (output valid, cmd, item_data, item_priority, input ready);
    modport sink   (input valid, cmd, item_data, item_priority, output ready);
endinterface

interface pqft_rsp_if import pqft_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] out_data;
    logic [PRIO_W-1:0]        out_priority;
    logic [OCC_W-1:0]         occupancy;

    modport source (output valid, status, out_data, out_priority, occupancy, input ready);
    modport sink   (input valid, status, out_data, out_priority, occupancy, output ready);
endinterface

/* rtl/pqft_cell.sv */
// One queue slot: holds an entry, folds it into the running maximum,
// and takes the insert word or its right neighbor on removal. Depends on pqft_pkg.
module pqft_cell import pqft_pkg::*; (
    input  logic             i_clk,
    input  logic [IDX_W-1:0] i_index,
    input  t_cell_ctl        i_ctl,
    input  t_slot            i_ins_slot,
    input  t_slot            i_next_slot,
    input  t_carry           i_carry,
    output t_carry           o_carry,
    output t_slot            o_slot
);

    t_slot  r_slot;
    t_slot  n_slot;
    t_carry r_carry;
    t_carry n_carry;
    logic   w_valid;

    // slot holds a live entry when its position is below the count
    assign w_valid = (CNT_W'(i_index) < i_ctl.count);

    // running max; strict compare keeps the older entry on a tie
    always_comb begin
        n_carry = i_carry;
        if (w_valid && (!i_carry.any || (r_slot.prio > i_carry.prio))) begin
            n_carry.any  = 1'b1;
            n_carry.prio = r_slot.prio;
            n_carry.idx  = i_index;
            n_carry.data = r_slot.data;
        end
    end

    // append at tail, or close the gap at and after the removed slot
    always_comb begin
        n_slot = r_slot;
        if (i_ctl.wr_ins && (CNT_W'(i_index) == i_ctl.count)) begin
            n_slot = i_ins_slot;
        end else if (i_ctl.shift && (i_index >= i_ctl.best_idx)) begin
            n_slot = i_next_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot  <= n_slot;
        r_carry <= n_carry;
    end

    assign o_carry = r_carry;
    assign o_slot  = r_slot;

endmodule

/* rtl/max_priority_queue_fifo_ties.sv */
// Max priority queue with oldest-first ties, built as a chain of slot cells.
// Insert, full and underflow: the result passes the pending and output registers.
// Remove: the running maximum ripples through the DEPTH-cell chain, then the result
// passes the same registers. A new request is taken only when idle with pending empty.
// Reset (i_rst_n low, synchronous) empties the queue and drops pending results.
// Depends on pqft_pkg, pqft_if, pqft_cell and the assertion macro header.
`include "max_priority_queue_fifo_ties_macros.svh"

module max_priority_queue_fifo_ties import pqft_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pqft_req_if.sink      i_req,
    pqft_rsp_if.source    o_rsp
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;
    localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic             r_state,  n_state;
    logic [CNT_W-1:0] r_scan,   n_scan;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             r_pend_v, n_pend_v;
    t_rsp             r_pend,   n_pend;
    logic             r_out_v,  n_out_v;
    t_rsp             r_out,    n_out;

    logic      w_accept;
    logic      w_scan_done;
    logic      w_move;
    t_cell_ctl w_ctl;
    t_slot     w_ins_slot;
    t_carry    w_carry [DEPTH+1];
    t_slot     w_slot  [DEPTH];

    assign i_req.ready = (r_state == S_IDLE) && !r_pend_v;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_scan_done = (r_state == S_SCAN) && (r_scan == SCAN_END);

    // broadcast control to the cells
    assign w_ctl.wr_ins   = w_accept && (i_req.cmd == CMD_INSERT) && (r_count != FULL_CNT);
    assign w_ctl.shift    = w_scan_done;
    assign w_ctl.best_idx = w_carry[DEPTH].idx;
    assign w_ctl.count    = r_count;

    assign w_ins_slot.prio = i_req.item_priority;
    assign w_ins_slot.data = i_req.item_data;

    // cell chain
    assign w_carry[0] = '0;

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_slot w_next;
        if (gi == DEPTH - 1) begin : g_last
            assign w_next = w_slot[gi];
        end else begin : g_mid
            assign w_next = w_slot[gi+1];
        end
        pqft_cell u_cell (
            .i_clk       (i_clk),
            .i_index     (IDX_W'(gi)),
            .i_ctl       (w_ctl),
            .i_ins_slot  (w_ins_slot),
            .i_next_slot (w_next),
            .i_carry     (w_carry[gi]),
            .o_carry     (w_carry[gi+1]),
            .o_slot      (w_slot[gi])
        );
    end

    // sequencer: insert, full and underflow finish at accept, removes wait out the scan
    always_comb begin
        n_state = r_state;
        n_scan  = r_scan;
        n_count = r_count;
        n_pend  = r_pend;
        n_pend_v = r_pend_v;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_pend.data = '0;
                    n_pend.prio = '0;
                    n_pend_v    = 1'b1;
                    if (i_req.cmd == CMD_INSERT) begin
                        if (r_count == FULL_CNT) begin
                            n_pend.status = ST_FULL;
                            n_pend.occ    = OCC_W'(r_count);
                        end else begin
                            n_count       = r_count + 1'b1;
                            n_pend.status = ST_INSERTED;
                            n_pend.occ    = OCC_W'(n_count);
                        end
                    end else if (r_count == '0) begin
                        n_pend.status = ST_UNDERFLOW;
                        n_pend.occ    = OCC_W'(r_count);
                    end else begin
                        n_pend_v = 1'b0;
                        n_state  = S_SCAN;
                        n_scan   = '0;
                    end
                end
            end
            S_SCAN: begin
                n_scan = r_scan + 1'b1;
                if (w_scan_done) begin
                    n_count       = r_count - 1'b1;
                    n_pend.status = ST_REMOVED;
                    n_pend.data   = w_carry[DEPTH].data;
                    n_pend.prio   = w_carry[DEPTH].prio;
                    n_pend.occ    = OCC_W'(n_count);
                    n_pend_v      = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // skid stage into the output register
        if (r_pend_v && w_move) begin
            n_pend_v = 1'b0;
        end
    end

    // output register
    assign w_move = !r_out_v || o_rsp.ready;

    always_comb begin
        n_out_v = r_out_v;
        n_out   = r_out;
        if (r_pend_v && w_move) begin
            n_out_v = 1'b1;
            n_out   = r_pend;
        end else if (r_out_v && o_rsp.ready) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_scan   <= '0;
            r_count  <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_scan   <= n_scan;
            r_count  <= n_count;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_rsp.valid        = r_out_v;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.out_data     = r_out.data;
    assign o_rsp.out_priority = r_out.prio;
    assign o_rsp.occupancy    = r_out.occ;

    // checks
    `PQFT_ASSERT_NOW(a_count_bound, 1'b1, r_count <= FULL_CNT)
    `PQFT_ASSERT_NOW(a_scan_found, w_scan_done, w_carry[DEPTH].any)
    `PQFT_ASSERT_NEXT(a_remove_dec, w_scan_done, r_count == $past(r_count) - 1'b1)
    `PQFT_ASSERT_NEXT(a_insert_inc, w_ctl.wr_ins, r_count == $past(r_count) + 1'b1)

endmodule
